FILE: hw/rtl/ipsl_pkg.sv
// Shared types and constants for the incremental PID speed loop.
// Used by the configuration, sequencer and top-level modules; depends on nothing else.
package ipsl_pkg;

  // Field widths of the item and configuration ports.
  localparam int SPEED_W  = 12;
  localparam int DRIVE_W  = 13;
  localparam int GAIN_W   = 16;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // Gain format is Q8.8.
  localparam int GAIN_FRAC_BITS = 8;

  // Fixed control constants.
  localparam logic [DRIVE_W-1:0]        DRIVE_RESET  = 13'd2750;
  localparam logic signed [SPEED_W-1:0] CUTOFF_SPEED = 12'sd150;
  localparam logic signed [SPEED_W-1:0] FAST_SPEED   = 12'sd200;
  localparam int                        DIV_TEN      = 10;

  // Register indexes on the configuration port (byte address 4*index).
  localparam logic [1:0] REG_GAIN_I = 2'd0;
  localparam logic [1:0] REG_GAIN_P = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_COR1,
    ST_COR2,
    ST_ERR,
    ST_MULI,
    ST_MULP,
    ST_MULD,
    ST_ACC,
    ST_SCALE,
    ST_DRIVE
  } state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_DIV,
    MSEL_INT,
    MSEL_PROP,
    MSEL_DER
  } mul_sel_t;

  // Step strobes from the sequencer to the datapath.
  typedef struct packed {
    logic     in_ready;
    logic     ld_abs;
    logic     ld_cor1;
    logic     ld_cor2;
    logic     ld_err;
    logic     ld_diff;
    logic     acc_load;
    logic     acc_add;
    logic     ld_scale;
    logic     ld_drive;
    mul_sel_t mul_sel;
  } ctl_t;

endpackage

FILE: hw/rtl/ipsl_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing; the top level selects its operands.
module ipsl_mul #(
  parameter int W = 26
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hw/rtl/ipsl_apb.sv
// APB-style configuration registers holding the three Q8.8 loop gains.
// Depends on ipsl_pkg for widths and register indexes.
module ipsl_apb (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipsl_pkg::APB_AW-1:0]         paddr,
  input  logic [ipsl_pkg::APB_DW-1:0]         pwdata,
  output logic [ipsl_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  output logic signed [ipsl_pkg::GAIN_W-1:0]  gain_integral,
  output logic signed [ipsl_pkg::GAIN_W-1:0]  gain_proportional,
  output logic signed [ipsl_pkg::GAIN_W-1:0]  gain_derivative
);
  import ipsl_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Register writes; an index past the last gain is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_integral     <= '0;
      gain_proportional <= '0;
      gain_derivative   <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_GAIN_I: gain_integral     <= pwdata[GAIN_W-1:0];
        REG_GAIN_P: gain_proportional <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: gain_derivative   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign-extended to the bus width.
  always_comb begin
    case (reg_index)
      REG_GAIN_I: prdata = APB_DW'(gain_integral);
      REG_GAIN_P: prdata = APB_DW'(gain_proportional);
      REG_GAIN_D: prdata = APB_DW'(gain_derivative);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/ipsl_seq.sv
// Sequencer that steps one item through the filter, error and gain phases.
// Depends on ipsl_pkg for the state type and the step strobe struct.
module ipsl_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_free,
  output ipsl_pkg::ctl_t ctl
);
  import ipsl_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a fixed walk, waiting at the end while the result is unread.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ABS;
      ST_ABS:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_COR1;
      ST_COR1:  state_next = ST_COR2;
      ST_COR2:  state_next = ST_ERR;
      ST_ERR:   state_next = ST_MULI;
      ST_MULI:  state_next = ST_MULP;
      ST_MULP:  state_next = ST_MULD;
      ST_MULD:  state_next = ST_ACC;
      ST_ACC:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DRIVE;
      ST_DRIVE: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Step strobes and multiplier operand choice for each state.
  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MSEL_DIV;
    case (state)
      ST_IDLE:  ctl.in_ready = 1'b1;
      ST_ABS:   ctl.ld_abs = 1'b1;
      ST_DIV:   ctl.mul_sel = MSEL_DIV;
      ST_COR1:  ctl.ld_cor1 = 1'b1;
      ST_COR2:  ctl.ld_cor2 = 1'b1;
      ST_ERR:   ctl.ld_err = 1'b1;
      ST_MULI: begin
        ctl.mul_sel = MSEL_INT;
        ctl.ld_diff = 1'b1;
      end
      ST_MULP: begin
        ctl.mul_sel  = MSEL_PROP;
        ctl.acc_load = 1'b1;
      end
      ST_MULD: begin
        ctl.mul_sel = MSEL_DER;
        ctl.acc_add = 1'b1;
      end
      ST_ACC:   ctl.acc_add = 1'b1;
      ST_SCALE: ctl.ld_scale = 1'b1;
      ST_DRIVE: ctl.ld_drive = out_free;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/incremental_pid_speed_loop_unit.sv
// Incremental PID speed loop: top level with datapath, gains and sequencer.
// An accepted item walks the states from ABS to DRIVE before its result shows; the
// next item is taken only once the sequencer is idle, paced by the four passes
// through the one shared multiplier and the steps around them. A waiting result
// stalls only the final step. Synchronous reset clears the filter, error history and
// fast flag, sets the drive to 2750 and the gains to zero; there is no clearing pass.
module incremental_pid_speed_loop_unit #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int DRIVE_MAX       = 5500
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ipsl_pkg::APB_AW-1:0]          paddr,
  input  logic [ipsl_pkg::APB_DW-1:0]          pwdata,
  output logic [ipsl_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  // Input items.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ipsl_pkg::SPEED_W-1:0]  measured_speed,
  input  logic signed [ipsl_pkg::SPEED_W-1:0]  target_speed,
  input  logic                                 ramp_active,
  input  logic                                 finish_active,
  input  logic                                 loop_enable_in,
  // Result items.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ipsl_pkg::DRIVE_W-1:0]         drive_value,
  output logic                                 loop_enable_out,
  output logic signed [ipsl_pkg::SPEED_W-1:0]  filtered_speed
);
  import ipsl_pkg::*;

  // Filtered speed and its derived widths.
  localparam int SW  = SPEED_W + SPEED_FRAC_BITS;  // filtered speed
  localparam int FSW = SW + 4;                     // 6*old + 4*new, signed
  localparam int NW  = SW + 3;                     // its magnitude
  localparam int OW  = NW + 2;                     // multiplier operands
  localparam int K   = NW + 4;                     // reciprocal shift
  localparam int EW  = SW + 1;                     // error
  localparam int DW  = SW + 2;                     // error difference
  localparam int ACW = DW + GAIN_W + 2;            // sum of three products
  localparam int SH  = GAIN_FRAC_BITS + SPEED_FRAC_BITS;
  localparam int QW  = ACW - SH;                   // scaled drive step
  localparam int DSW = QW + 2;                     // drive plus step

  localparam longint unsigned RECIP_L = (64'd1 << K) / 64'd10;
  localparam logic [OW-1:0]   RECIP   = OW'(RECIP_L);
  localparam logic [ACW-1:0]  ACC_BIAS  = ACW'((64'd1 << SH) - 64'd1);
  localparam logic [SW-1:0]   FILT_BIAS = SW'((64'd1 << SPEED_FRAC_BITS) - 64'd1);
  localparam logic signed [DSW-1:0] DMAX_S   = DSW'(DRIVE_MAX);
  localparam logic [DRIVE_W-1:0]    DMAX_U   = DRIVE_W'(DRIVE_MAX);
  localparam logic [NW-1:0]         TEN_N    = NW'(DIV_TEN);

  ctl_t ctl;
  logic out_free;
  logic in_take;

  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_d;

  // Latched item.
  logic signed [SPEED_W-1:0] meas_lat;
  logic signed [SPEED_W-1:0] target_lat;
  logic                      ramp_lat;
  logic                      fin_lat;
  logic                      en_lat;

  // Datapath registers.
  logic signed [FSW-1:0] fsum;
  logic signed [FSW-1:0] fsum_next;
  logic signed [FSW-1:0] fsum_neg;
  logic signed [FSW-1:0] sf_ext;
  logic signed [FSW-1:0] meas_ext;
  logic                  fsign;
  logic [NW-1:0]         mag;
  logic [NW-1:0]         q0;
  logic [NW-1:0]         q0_next;
  logic [NW-1:0]         rem;
  logic [NW-1:0]         quot;
  logic [NW-1:0]         quot_signed;
  logic signed [SW-1:0]  speed_filtered;
  logic signed [EW-1:0]  err;
  logic signed [EW-1:0]  prev_err;
  logic signed [DW-1:0]  diff;
  logic signed [DW-1:0]  prev_diff;
  logic signed [ACW-1:0] acc;
  logic [ACW-1:0]        acc_biased;
  logic signed [QW-1:0]  qacc;
  logic [DRIVE_W-1:0]    drive;
  logic                  has_run_fast;

  // Drive update.
  logic                  cutoff;
  logic                  en_eff;
  logic signed [DSW-1:0] drive_ext;
  logic signed [DSW-1:0] step_ext;
  logic signed [DSW-1:0] dsum;
  logic [DRIVE_W-1:0]    drive_next;
  logic [SW-1:0]         filt_biased;

  // Shared multiplier.
  logic signed [OW-1:0]   mul_a;
  logic signed [OW-1:0]   mul_b;
  logic signed [2*OW-1:0] prod;

  ipsl_apb u_apb (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .gain_integral     (gain_i),
    .gain_proportional (gain_p),
    .gain_derivative   (gain_d)
  );

  ipsl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  ipsl_mul #(.W(OW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign in_ready = ctl.in_ready;
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Multiplier operands: reciprocal of ten for the filter, then the three gains.
  always_comb begin
    case (ctl.mul_sel)
      MSEL_DIV: begin
        mul_a = OW'(mag);
        mul_b = RECIP;
      end
      MSEL_INT: begin
        mul_a = OW'(gain_i);
        mul_b = OW'(err);
      end
      MSEL_PROP: begin
        mul_a = OW'(gain_p);
        mul_b = OW'(diff);
      end
      MSEL_DER: begin
        mul_a = OW'(gain_d);
        mul_b = OW'(prev_diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Filter numerator 6*old + 4*new with the new speed in fixed point.
  assign sf_ext    = FSW'(speed_filtered);
  assign meas_ext  = FSW'(measured_speed);
  assign fsum_next = (sf_ext <<< 2) + (sf_ext <<< 1) + (meas_ext <<< (SPEED_FRAC_BITS + 2));
  assign fsum_neg  = -fsum;

  // Quotient estimate from the reciprocal product, then one correction.
  assign q0_next     = prod[K +: NW];
  assign quot        = q0 + NW'(rem >= TEN_N);
  assign quot_signed = fsign ? -quot : quot;

  // Item latch and filter steps.
  always_ff @(posedge clk) begin
    if (in_take) begin
      meas_lat   <= measured_speed;
      target_lat <= target_speed;
      ramp_lat   <= ramp_active;
      fin_lat    <= finish_active;
      en_lat     <= loop_enable_in;
      fsum       <= fsum_next;
    end
    if (ctl.ld_abs) begin
      fsign <= fsum[FSW-1];
      mag   <= fsum[FSW-1] ? fsum_neg[NW-1:0] : fsum[NW-1:0];
    end
    if (ctl.ld_cor1) begin
      q0  <= q0_next;
      rem <= mag - ((q0_next << 3) + (q0_next << 1));
    end
  end

  // Error, difference and gain accumulation.
  always_ff @(posedge clk) begin
    if (ctl.ld_err) begin
      err <= (EW'(target_lat) <<< SPEED_FRAC_BITS) - EW'(speed_filtered);
    end
    if (ctl.ld_diff) begin
      diff <= DW'(err) - DW'(prev_err);
    end
    if (ctl.acc_load) begin
      acc <= prod[ACW-1:0];
    end else if (ctl.acc_add) begin
      acc <= acc + prod[ACW-1:0];
    end
    if (ctl.ld_scale) begin
      qacc <= acc_biased[ACW-1:SH];
    end
  end

  // Truncate toward zero when dropping the fraction bits.
  assign acc_biased = acc + (acc[ACW-1] ? ACC_BIAS : '0);

  // Low-speed cutoff uses the fast flag from before this item.
  assign cutoff = !ramp_lat && !fin_lat && has_run_fast &&
                  (meas_lat > 12'sd0) && (meas_lat < CUTOFF_SPEED);
  assign en_eff = en_lat && !cutoff;

  // Drive step and clamp to 0..DRIVE_MAX.
  assign drive_ext = DSW'({1'b0, drive});
  assign step_ext  = en_eff ? DSW'(qacc) : '0;
  assign dsum      = drive_ext + step_ext;

  always_comb begin
    if (dsum < 0) begin
      drive_next = '0;
    end else if (dsum > DMAX_S) begin
      drive_next = DMAX_U;
    end else begin
      drive_next = dsum[DRIVE_W-1:0];
    end
  end

  // Integer part of the filtered speed, truncated toward zero.
  assign filt_biased = speed_filtered + (speed_filtered[SW-1] ? FILT_BIAS : '0);

  // Loop state carried from item to item.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_filtered <= '0;
      prev_err       <= '0;
      prev_diff      <= '0;
      drive          <= DRIVE_RESET;
      has_run_fast   <= 1'b0;
    end else begin
      if (ctl.ld_cor2) begin
        speed_filtered <= quot_signed[SW-1:0];
      end
      if (ctl.ld_drive) begin
        drive     <= drive_next;
        prev_err  <= err;
        prev_diff <= diff;
        if (meas_lat > FAST_SPEED) begin
          has_run_fast <= 1'b1;
        end
      end
    end
  end

  // Output register; a new result may be loaded as the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.ld_drive) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_drive) begin
      drive_value     <= drive_next;
      loop_enable_out <= en_eff;
      filtered_speed  <= filt_biased[SPEED_FRAC_BITS +: SPEED_W];
    end
  end

  // The drive shown never leaves its clamp range.
  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_value <= DMAX_U)
    else $error("drive above its upper clamp");

  // Once an item is taken the block is busy on the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");

  // Only reset clears the fast flag.
  a_fast_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(has_run_fast))
    else $error("fast flag cleared outside reset");

endmodule
